>>> design/hex27_pkg.sv
// Shared constants, codes and node tables for the 27-node hexahedron shape function unit.
package hex27_pkg;

  localparam int COORD_FRAC_BITS = 14;
  localparam int OUT_FRAC_BITS   = 24;
  localparam int COORD_W         = 16;
  localparam int OUT_W           = 32;
  localparam int NODE_W          = 5;
  localparam int NODE_COUNT      = 27;
  localparam int MAG_W           = 32;
  localparam int PROD2_W         = 2 * MAG_W;
  localparam int HALF_W          = MAG_W / 2;
  localparam int PART_W          = PROD2_W + HALF_W;
  localparam int SUM_W           = 3 * MAG_W;
  localparam int ROUND_SHIFT     = 3 * (2 * COORD_FRAC_BITS + 1) - OUT_FRAC_BITS;
  localparam int QUOT_W          = SUM_W - ROUND_SHIFT;
  localparam int FACT_W          = 35;

  typedef enum logic [1:0] {
    FUNC_VALUE,
    FUNC_DR,
    FUNC_DS,
    FUNC_DT
  } func_t;

  typedef enum logic [1:0] {
    KIND_MINUS,
    KIND_MIDDLE,
    KIND_PLUS
  } kind_t;

  typedef struct packed {
    kind_t r;
    kind_t s;
    kind_t t;
  } node_kinds_t;

  typedef struct packed {
    logic [MAG_W-1:0] mag;
    logic             neg;
  } factor_t;

  function automatic node_kinds_t node_kinds(input logic [NODE_W-1:0] node);
    node_kinds_t k;
    case (node)
      5'd0:    k = '{KIND_MINUS,  KIND_MINUS,  KIND_MINUS};
      5'd1:    k = '{KIND_PLUS,   KIND_MINUS,  KIND_MINUS};
      5'd2:    k = '{KIND_PLUS,   KIND_PLUS,   KIND_MINUS};
      5'd3:    k = '{KIND_MINUS,  KIND_PLUS,   KIND_MINUS};
      5'd4:    k = '{KIND_MINUS,  KIND_MINUS,  KIND_PLUS};
      5'd5:    k = '{KIND_PLUS,   KIND_MINUS,  KIND_PLUS};
      5'd6:    k = '{KIND_PLUS,   KIND_PLUS,   KIND_PLUS};
      5'd7:    k = '{KIND_MINUS,  KIND_PLUS,   KIND_PLUS};
      5'd8:    k = '{KIND_MIDDLE, KIND_MINUS,  KIND_MINUS};
      5'd9:    k = '{KIND_MINUS,  KIND_MIDDLE, KIND_MINUS};
      5'd10:   k = '{KIND_MINUS,  KIND_MINUS,  KIND_MIDDLE};
      5'd11:   k = '{KIND_PLUS,   KIND_MIDDLE, KIND_MINUS};
      5'd12:   k = '{KIND_PLUS,   KIND_MINUS,  KIND_MIDDLE};
      5'd13:   k = '{KIND_MIDDLE, KIND_PLUS,   KIND_MINUS};
      5'd14:   k = '{KIND_PLUS,   KIND_PLUS,   KIND_MIDDLE};
      5'd15:   k = '{KIND_MINUS,  KIND_PLUS,   KIND_MIDDLE};
      5'd16:   k = '{KIND_MIDDLE, KIND_MINUS,  KIND_PLUS};
      5'd17:   k = '{KIND_MINUS,  KIND_MIDDLE, KIND_PLUS};
      5'd18:   k = '{KIND_PLUS,   KIND_MIDDLE, KIND_PLUS};
      5'd19:   k = '{KIND_MIDDLE, KIND_PLUS,   KIND_PLUS};
      5'd20:   k = '{KIND_MIDDLE, KIND_MIDDLE, KIND_MINUS};
      5'd21:   k = '{KIND_MIDDLE, KIND_MINUS,  KIND_MIDDLE};
      5'd22:   k = '{KIND_MINUS,  KIND_MIDDLE, KIND_MIDDLE};
      5'd23:   k = '{KIND_PLUS,   KIND_MIDDLE, KIND_MIDDLE};
      5'd24:   k = '{KIND_MIDDLE, KIND_PLUS,   KIND_MIDDLE};
      5'd25:   k = '{KIND_MIDDLE, KIND_MIDDLE, KIND_PLUS};
      5'd26:   k = '{KIND_MIDDLE, KIND_MIDDLE, KIND_MIDDLE};
      default: k = '{KIND_MINUS,  KIND_MINUS,  KIND_MINUS};
    endcase
    return k;
  endfunction

  // 1-D factor with 2F+1 fraction bits, returned as sign and magnitude
  function automatic factor_t axis_factor(input logic signed [COORD_W-1:0] x,
                                          input kind_t kind, input logic deriv);
    logic signed [COORD_W:0]     xe;
    logic signed [COORD_W:0]     b;
    logic signed [2*COORD_W+1:0] prod;
    logic signed [COORD_W+2:0]   d;
    logic signed [FACT_W-1:0]    v;
    logic signed [FACT_W-1:0]    nv;
    factor_t                     f;
    xe = {x[COORD_W-1], x};
    case (kind)
      KIND_MINUS: b = xe - (COORD_W+1)'(1 << COORD_FRAC_BITS);
      KIND_PLUS:  b = xe + (COORD_W+1)'(1 << COORD_FRAC_BITS);
      default:    b = xe;
    endcase
    prod = xe * b;
    case (kind)
      KIND_MINUS: d = {xe[COORD_W], xe, 1'b0} - (COORD_W+3)'(1 << COORD_FRAC_BITS);
      KIND_PLUS:  d = {xe[COORD_W], xe, 1'b0} + (COORD_W+3)'(1 << COORD_FRAC_BITS);
      default:    d = (COORD_W+3)'(0) - {xe, 2'b00};
    endcase
    if (deriv) begin
      v = {{(FACT_W-COORD_W-3-COORD_FRAC_BITS){d[COORD_W+2]}}, d, COORD_FRAC_BITS'(0)};
    end else if (kind == KIND_MIDDLE) begin
      v = FACT_W'(1 << (2 * COORD_FRAC_BITS + 1)) - {prod, 1'b0};
    end else begin
      v = {prod[2*COORD_W+1], prod};
    end
    nv = FACT_W'(0) - v;
    f.neg = v[FACT_W-1];
    f.mag = f.neg ? nv[MAG_W-1:0] : v[MAG_W-1:0];
    return f;
  endfunction

endpackage

>>> design/hex27_shape_function_eval_top.sv
// Pipelined evaluator of one 27-node hexahedron shape function or derivative per cycle while the result is not stalled.
//
//   channel  | handshake                  | words
//   ---------+----------------------------+-------------------------------------
//   item     | item_valid / item_stall    | node, func, coord_r, coord_s, coord_t
//   result   | result_valid / result_stall| shape_value, node_ok
//
// One word enters per cycle unless the result is stalled; each result passes through the stages below in order.
// Stages: 1-D factors (three 17x17 multiplies), r*s product (32x32),
// two 64x16 partial products, 96-bit sum with rounding bit, shift/saturate/sign.
// Reset (rst, synchronous) clears the stage valid bits; payload is not reset.
// A stalled result holds the whole pipeline, so item_stall follows it directly.
module hex27_shape_function_eval_top
  import hex27_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      item_valid,
  output logic                      item_stall,
  input  logic [NODE_W-1:0]         node,
  input  logic [1:0]                func,
  input  logic signed [COORD_W-1:0] coord_r,
  input  logic signed [COORD_W-1:0] coord_s,
  input  logic signed [COORD_W-1:0] coord_t,
  output logic                      result_valid,
  input  logic                      result_stall,
  output logic signed [OUT_W-1:0]   shape_value,
  output logic                      node_ok
);

  logic        advance;
  node_kinds_t kinds;
  logic        in_ok;
  factor_t     fr_next;
  factor_t     fs_next;
  factor_t     ft_next;

  logic               v1;
  logic               ok1;
  factor_t            fr;
  factor_t            fs;
  factor_t            ft;

  logic               v2;
  logic               ok2;
  logic               neg2;
  logic [PROD2_W-1:0] p01;
  logic [MAG_W-1:0]   mag2;

  logic               v3;
  logic               ok3;
  logic               neg3;
  logic [PART_W-1:0]  plo;
  logic [PART_W-1:0]  phi;

  logic               v4;
  logic               ok4;
  logic               neg4;
  logic [SUM_W-1:0]   sum;

  logic [QUOT_W-1:0]  quot;
  logic [QUOT_W-1:0]  limit;
  logic [QUOT_W-1:0]  mag_sat;
  logic [QUOT_W-1:0]  signed_val;

  assign advance    = !(result_valid && result_stall);
  assign item_stall = !advance;

  assign kinds = node_kinds(node);
  assign in_ok = (node < NODE_W'(NODE_COUNT));

  always_comb begin
    fr_next = axis_factor(coord_r, kinds.r, func == FUNC_DR);
    fs_next = axis_factor(coord_s, kinds.s, func == FUNC_DS);
    ft_next = axis_factor(coord_t, kinds.t, func == FUNC_DT);
    // drop invalid nodes to a zero product
    if (!in_ok) begin
      fr_next = '0;
    end
  end

  assign quot       = sum[SUM_W-1:ROUND_SHIFT];
  assign limit      = neg4 ? QUOT_W'(64'd1 << (OUT_W - 1))
                           : QUOT_W'((64'd1 << (OUT_W - 1)) - 64'd1);
  assign mag_sat    = (quot > limit) ? limit : quot;
  assign signed_val = neg4 ? (QUOT_W'(0) - mag_sat) : mag_sat;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1           <= 1'b0;
      v2           <= 1'b0;
      v3           <= 1'b0;
      v4           <= 1'b0;
      result_valid <= 1'b0;
    end else if (advance) begin
      v1           <= item_valid;
      v2           <= v1;
      v3           <= v2;
      v4           <= v3;
      result_valid <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      ok1         <= in_ok;
      fr          <= fr_next;
      fs          <= fs_next;
      ft          <= ft_next;

      ok2         <= ok1;
      neg2        <= fr.neg ^ fs.neg ^ ft.neg;
      p01         <= PROD2_W'(fr.mag) * PROD2_W'(fs.mag);
      mag2        <= ft.mag;

      ok3         <= ok2;
      neg3        <= neg2;
      plo         <= PART_W'(p01) * PART_W'(mag2[HALF_W-1:0]);
      phi         <= PART_W'(p01) * PART_W'(mag2[MAG_W-1:HALF_W]);

      ok4         <= ok3;
      neg4        <= neg3;
      sum         <= SUM_W'(plo) + {phi, HALF_W'(0)} + (SUM_W'(1) << (ROUND_SHIFT - 1));

      node_ok     <= ok4;
      shape_value <= signed_val[OUT_W-1:0];
    end
  end

  a_reset_clears: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid after reset");

  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !node_ok) |-> (shape_value == '0))
    else $error("invalid node gave nonzero value");

  a_stall_backpressure: assert property (@(posedge clk) disable iff (rst)
    item_stall == (result_valid && result_stall))
    else $error("item stall does not follow result stall");

  a_bubble_drains: assert property (@(posedge clk) disable iff (rst)
    (!v4 && !item_stall) |=> !result_valid)
    else $error("result appeared without a word in the last stage");

  a_word_advances: assert property (@(posedge clk) disable iff (rst)
    (v4 && !item_stall) |=> result_valid)
    else $error("word lost in the last stage");

endmodule
